### rtl/wfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfm_pkg;

  // Widths fixed by the item fields and the stored samples.
  localparam int COUNT_W     = 16;
  localparam int SCALE_W     = 8;
  localparam int SAMPLE_W    = COUNT_W + SCALE_W;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;

  localparam int RING_DEPTH_DEF = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd25;

  // Item kinds carried in the action bit.
  localparam logic ACT_PULSE = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  typedef struct packed {
    logic pulse;      // pulse item accepted
    logic close;      // window-close item accepted
    logic rd_issue;   // read the next ring entry
    logic div_start;  // start the divider on the trimmed sum
    logic out_load;   // load the output register
  } wfm_cmd_t;

  typedef struct packed {
    logic walk_last;  // the read issued now is the last ring entry
    logic div_done;   // the divider finishes at this edge
  } wfm_stat_t;

endpackage

`default_nettype wire

### rtl/wfm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module wfm_div #(
  parameter int DVD_W   = 27,
  parameter int DIVISOR = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  // Floor division by a constant through a reciprocal multiply. With
  // SHIFT = DVD_W + clog2(DIVISOR) and RECIP = ceil(2^SHIFT / DIVISOR), the
  // bits of dividend * RECIP above SHIFT give the exact floor quotient for
  // every DVD_W-bit dividend. The dividend is registered at start; done is high
  // in the cycle after start, and the product is registered at the end of it.
  localparam int MUL_W  = DVD_W + 1;
  localparam int PROD_W = DVD_W + MUL_W;
  localparam int SHIFT  = DVD_W + $clog2(DIVISOR);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

  logic              mul_go_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_go_r <= 1'b0;
    end else begin
      mul_go_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (mul_go_r) begin
      prod_r <= PROD_W'(dvd_r) * PROD_W'(RECIP);
    end
  end

  assign done     = mul_go_r;
  assign quotient = DVD_W'(prod_r >> SHIFT);

endmodule

`default_nettype wire

### rtl/wfm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wfm_ctrl
  import wfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_action,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire wfm_stat_t stat,
  output wfm_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.pulse     = accept && (in_action == ACT_PULSE);
    cmd.close     = accept && (in_action == ACT_CLOSE);
    case (state_r)
      S_IDLE: begin
        if (cmd.close) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

### rtl/wfm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module wfm_dp
  import wfm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wfm_cmd_t            cmd,
  output wfm_stat_t                stat,
  input  wire logic                in_channel,
  input  wire logic                cfg_wr_en,
  input  wire logic [SCALE_W-1:0]  cfg_wr_data,
  output logic                     out_channel,
  output logic      [SAMPLE_W-1:0] out_avg
);

  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int ENTRIES = 2 * RING_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int SUM_W   = SAMPLE_W + $clog2(RING_DEPTH);

  logic [SCALE_W-1:0]  scale_r;
  logic [COUNT_W-1:0]  pcount_r [2];
  logic [IDX_W-1:0]    ring_idx_r [2];
  logic [ENTRIES-1:0]  valid_r;
  logic                ch_r;
  logic [IDX_W-1:0]    walk_idx_r;
  logic                rd_pend_r;
  logic [SAMPLE_W-1:0] ring_mem [ENTRIES];
  logic [SAMPLE_W-1:0] rdata_r;
  logic                rvalid_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] max_r, min_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic                out_ch_r;

  logic [SAMPLE_W-1:0] product;
  logic [IDX_W-1:0]    wr_idx, wr_idx_nxt;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [SAMPLE_W-1:0] rd_val;
  logic [SUM_W-1:0]    trimmed;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;

  // Entries never written since reset read as zero through their valid bit.
  assign wr_idx     = ring_idx_r[in_channel];
  assign wr_idx_nxt = (wr_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx + IDX_W'(1);
  assign wr_addr    = in_channel ? ADDR_W'(RING_DEPTH) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
  assign rd_addr    = ch_r ? ADDR_W'(RING_DEPTH) + ADDR_W'(walk_idx_r) : ADDR_W'(walk_idx_r);
  assign product    = SAMPLE_W'(pcount_r[in_channel]) * SAMPLE_W'(scale_r);
  assign rd_val     = rvalid_r ? rdata_r : '0;
  assign trimmed    = sum_r - SUM_W'(max_r) - SUM_W'(min_r);

  assign stat.walk_last = (walk_idx_r == IDX_W'(RING_DEPTH - 1));
  assign stat.div_done  = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r       <= SCALE_RESET;
      pcount_r[0]   <= '0;
      pcount_r[1]   <= '0;
      ring_idx_r[0] <= '0;
      ring_idx_r[1] <= '0;
      valid_r       <= '0;
      rd_pend_r     <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_issue;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (cmd.pulse && (pcount_r[in_channel] != COUNT_MAX)) begin
        pcount_r[in_channel] <= pcount_r[in_channel] + COUNT_W'(1);
      end
      if (cmd.close) begin
        pcount_r[in_channel]   <= '0;
        ring_idx_r[in_channel] <= wr_idx_nxt;
        valid_r[wr_addr]       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      ring_mem[wr_addr] <= product;
    end
    rdata_r  <= ring_mem[rd_addr];
    rvalid_r <= valid_r[rd_addr];
  end

  // Walk and accumulate sum, maximum and minimum.
  always_ff @(posedge clk) begin
    if (cmd.close) begin
      ch_r       <= in_channel;
      walk_idx_r <= '0;
      sum_r      <= '0;
      max_r      <= '0;
      min_r      <= '1;
    end else begin
      if (cmd.rd_issue) begin
        walk_idx_r <= walk_idx_r + IDX_W'(1);
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(rd_val);
        if (rd_val > max_r) begin
          max_r <= rd_val;
        end
        if (rd_val < min_r) begin
          min_r <= rd_val;
        end
      end
    end
    if (cmd.out_load) begin
      out_avg_r <= quotient[SAMPLE_W-1:0];
      out_ch_r  <= ch_r;
    end
  end

  wfm_div #(
    .DVD_W   (SUM_W),
    .DIVISOR (RING_DEPTH - 2)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (trimmed),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_channel = out_ch_r;
  assign out_avg     = out_avg_r;

endmodule

`default_nettype wire

### rtl/windowed_freq_trimmed_mean.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-channel pulse-frequency meter with a trimmed-mean report.
// Input channel (in_*): each item is a pulse seen on a channel or the close of
// that channel's measurement window. A pulse raises the channel's count, which
// saturates at 65535; the block stays ready after a pulse.
// A window close stores count times count_scale in the channel's ring, clears
// the count, then walks the ring one entry per cycle through the sample memory
// port and divides sum minus max minus min by RING_DEPTH-2 with a registered
// multiply by the divisor's reciprocal.
// After the close is accepted, the block reads the ring, drains the last read,
// starts and completes the division and loads the output register, and
// in_tready stays low until the result sits in the output register.
// If the receiver stalls, the result waits in the output register; pulse items
// keep being accepted, and a later close finishes its walk and division but
// then waits until the previous result has been taken.
// Reset (rst_n low, synchronous) clears the counts, ring positions and ring
// valid bits, so early reports include zeros, and sets count_scale to 25.
// cfg_wr_en writes count_scale; do it only while no window close is pending.
module windowed_freq_trimmed_mean
  import wfm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [TDATA_IN_W-1:0]  in_tdata,    // [0] action, [7:1] zero
  input  wire logic [0:0]             in_tuser,    // [0] channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [TDATA_OUT_W-1:0] out_tdata,   // [23:0] average_freq
  output logic      [0:0]             out_tuser,   // [0] result_channel
  input  wire logic                   cfg_wr_en,
  input  wire logic [SCALE_W-1:0]     cfg_wr_data  // count_scale
);

  wfm_cmd_t  cmd;
  wfm_stat_t stat;

  // The controller sequences accept, ring walk, division and output load.
  wfm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tdata[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds counts, rings, accumulators, divider and result.
  wfm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_channel  (in_tuser[0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_channel (out_tuser[0]),
    .out_avg     (out_tdata)
  );

endmodule

`default_nettype wire
